FILE: design/ata_pkg.sv
`default_nettype none

package ata_pkg;

   // widths of the datapath
   localparam int SumW  = 32;   // ay^2 + az^2 fits in 32 bits unsigned
   localparam int RadW  = 48;   // radicand is the sum shifted up by 16
   localparam int RootW = 24;   // floor root of a 48-bit radicand
   localparam int RemW  = 27;   // partial remainder of the root recurrence
   localparam int NumW  = 24;   // numerator is the sample shifted up by 8
   localparam int VecW  = 28;   // cordic x and y with headroom for gain
   localparam int AngW  = 26;   // angle accumulator in degrees * 65536
   localparam int TableLen = 24;

   typedef logic [RootW-1:0]        root_type;
   typedef logic signed [NumW-1:0]  num_type;
   typedef logic signed [VecW-1:0]  vec_type;
   typedef logic signed [AngW-1:0]  ang_type;

   localparam ang_type Deg90Q16 = 26'sd5898240;
   localparam ang_type RoundQ8  = 26'sd128;

   // atan(2^-i) in degrees * 65536, rounded to nearest
   localparam ang_type AtanTable [TableLen] = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
      26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
      26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
      26'sd917,     26'sd458,     26'sd229,    26'sd115,
      26'sd57,      26'sd29,      26'sd14,     26'sd7,
      26'sd4,       26'sd2,       26'sd1,      26'sd0
   };

endpackage

`default_nettype wire

FILE: design/ata_sqrt.sv
`default_nettype none

// pipelined floor square root, one result bit per stage
module ata_sqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       en,
   input  wire logic                       in_valid,
   input  wire logic [ata_pkg::SumW-1:0]   in_sum,
   input  wire ata_pkg::num_type           in_num,
   output logic                            out_valid,
   output ata_pkg::root_type               out_root,
   output ata_pkg::num_type                out_num
);

   localparam int Steps = ata_pkg::RootW;

   logic                          valid_ff [Steps];
   logic [ata_pkg::RemW-1:0]      rem_ff   [Steps];
   logic [ata_pkg::RemW-1:0]      rem_in   [Steps];
   ata_pkg::root_type             root_ff  [Steps];
   ata_pkg::root_type             root_in  [Steps];
   logic [ata_pkg::RadW-1:0]      rad_ff   [Steps];
   logic [ata_pkg::RadW-1:0]      rad_in   [Steps];
   ata_pkg::num_type              num_ff   [Steps];

   for (genvar k = 0; k < Steps; k++) begin : g_stage
      logic                     valid_prev;
      logic [ata_pkg::RemW-1:0] rem_prev;
      ata_pkg::root_type        root_prev;
      logic [ata_pkg::RadW-1:0] rad_prev;
      ata_pkg::num_type         num_prev;
      logic [ata_pkg::RemW-1:0] rem_sh;
      logic [ata_pkg::RemW-1:0] trial;
      logic                     take;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = {in_sum, 16'd0};
         assign num_prev   = in_num;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign num_prev   = num_ff[k-1];
      end

      always_comb begin
         rem_sh     = {rem_prev[ata_pkg::RemW-3:0], rad_prev[ata_pkg::RadW-1 -: 2]};
         trial      = {1'b0, root_prev, 2'b01};
         take       = (rem_sh >= trial);
         rem_in[k]  = take ? (rem_sh - trial) : rem_sh;
         root_in[k] = {root_prev[ata_pkg::RootW-2:0], take};
         rad_in[k]  = {rad_prev[ata_pkg::RadW-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
            num_ff[k]  <= num_prev;
         end
      end
   end

   assign out_valid = valid_ff[Steps-1];
   assign out_root  = root_ff[Steps-1];
   assign out_num   = num_ff[Steps-1];

endmodule

`default_nettype wire

FILE: design/ata_cordic.sv
`default_nettype none

// vectoring cordic, one micro-rotation per stage
module ata_cordic #(
   parameter int Steps = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic                 in_valid,
   input  wire ata_pkg::root_type    in_den,
   input  wire ata_pkg::num_type     in_num,
   output logic                      out_valid,
   output logic                      out_zero,
   output ata_pkg::ang_type          out_ang
);

   logic              valid_ff [Steps];
   logic              zero_ff  [Steps];
   ata_pkg::vec_type  x_ff     [Steps];
   ata_pkg::vec_type  x_in     [Steps];
   ata_pkg::vec_type  y_ff     [Steps];
   ata_pkg::vec_type  y_in     [Steps];
   ata_pkg::ang_type  z_ff     [Steps];
   ata_pkg::ang_type  z_in     [Steps];

   for (genvar i = 0; i < Steps; i++) begin : g_stage
      logic             valid_prev;
      logic             zero_prev;
      ata_pkg::vec_type x_prev;
      ata_pkg::vec_type y_prev;
      ata_pkg::ang_type z_prev;
      ata_pkg::vec_type xs;
      ata_pkg::vec_type ys;
      logic             up;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign zero_prev  = (in_den == '0) && (in_num == '0);
         assign x_prev     = ata_pkg::vec_type'({4'd0, in_den});
         assign y_prev     = ata_pkg::vec_type'(in_num);
         assign z_prev     = '0;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign zero_prev  = zero_ff[i-1];
         assign x_prev     = x_ff[i-1];
         assign y_prev     = y_ff[i-1];
         assign z_prev     = z_ff[i-1];
      end

      always_comb begin
         xs      = x_prev >>> i;
         ys      = y_prev >>> i;
         up      = (y_prev > 0);
         x_in[i] = up ? (x_prev + ys) : (x_prev - ys);
         y_in[i] = up ? (y_prev - xs) : (y_prev + xs);
         z_in[i] = up ? (z_prev + ata_pkg::AtanTable[i])
                      : (z_prev - ata_pkg::AtanTable[i]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_prev;
         end
         if (en) begin
            zero_ff[i] <= zero_prev;
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
         end
      end
   end

   assign out_valid = valid_ff[Steps-1];
   assign out_zero  = zero_ff[Steps-1];
   assign out_ang   = z_ff[Steps-1];

endmodule

`default_nettype wire

FILE: design/accel_tilt_angle_alert.sv
`default_nettype none

// tilt angles and alert from one accelerometer sample
//
// req channel: one transaction carries a signed 16-bit x, y, z sample
// rsp channel: one transaction per sample with pitch and roll in signed
//   q8.8 degrees (within +-90) and an alert flag
// csr port: apb-style, one register tilt_limit at byte address 0
//   (q8.8 degrees, reset 30 degrees), read back on csr_prdata
//
// a new sample is taken every cycle unless the output stalls; the pipeline
// is a squaring register, a summing register, the bit-per-stage square root,
// one cordic micro-rotation per stage and a final register for rounding and
// the limit compare
// when the receiver stalls the whole pipeline holds in place, so req_ready
// falls in the same cycle as a stalled result; nothing is dropped or repeated
// reset empties the pipeline and restores the limit to 30 degrees; req_ready
// stays low while reset is held

module accel_tilt_angle_alert #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic signed [15:0]  req_accel_x,
   input  wire logic signed [15:0]  req_accel_y,
   input  wire logic signed [15:0]  req_accel_z,

   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [15:0]       rsp_pitch_angle,
   output logic signed [15:0]       rsp_roll_angle,
   output logic                     rsp_tilt_alert,

   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [2:0]          csr_paddr,
   input  wire logic [31:0]         csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam logic [0:0] RegTiltLimit = 1'b0;
   localparam logic signed [15:0] Deg90Q8 = 16'sd23040;

   // global advance: the pipeline moves whenever the output slot is free
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en && !reset;

   // configuration register
   logic [14:0] tilt_limit_ff;
   logic        csr_write;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_limit_ff <= 15'd7680;
      end else if (csr_write && (csr_paddr[2] == RegTiltLimit)) begin
         tilt_limit_ff <= csr_pwdata[14:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == RegTiltLimit) begin
         csr_prdata = {17'd0, tilt_limit_ff};
      end
   end

   // stage 1: squares
   logic               s1_valid_ff;
   logic signed [15:0] s1_x_ff, s1_y_ff;
   logic [30:0]        s1_xx_ff, s1_yy_ff, s1_zz_ff;
   logic signed [31:0] xx_in, yy_in, zz_in;

   always_comb begin
      xx_in = req_accel_x * req_accel_x;
      yy_in = req_accel_y * req_accel_y;
      zz_in = req_accel_z * req_accel_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
      end
      if (en) begin
         s1_x_ff  <= req_accel_x;
         s1_y_ff  <= req_accel_y;
         s1_xx_ff <= xx_in[30:0];
         s1_yy_ff <= yy_in[30:0];
         s1_zz_ff <= zz_in[30:0];
      end
   end

   // stage 2: sums of squares and scaled numerators
   logic                    s2_valid_ff;
   logic [ata_pkg::SumW-1:0] s2_sum_p_ff, s2_sum_r_ff;
   ata_pkg::num_type        s2_num_p_ff, s2_num_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_sum_p_ff <= {1'b0, s1_yy_ff} + {1'b0, s1_zz_ff};
         s2_sum_r_ff <= {1'b0, s1_xx_ff} + {1'b0, s1_zz_ff};
         s2_num_p_ff <= {s1_x_ff, 8'd0};
         s2_num_r_ff <= {s1_y_ff, 8'd0};
      end
   end

   // square roots of the denominators
   logic              sq_p_valid, sq_r_valid;
   ata_pkg::root_type sq_p_root, sq_r_root;
   ata_pkg::num_type  sq_p_num, sq_r_num;

   ata_sqrt u_sqrt_pitch (
      .clock, .reset, .en,
      .in_valid  (s2_valid_ff),
      .in_sum    (s2_sum_p_ff),
      .in_num    (s2_num_p_ff),
      .out_valid (sq_p_valid),
      .out_root  (sq_p_root),
      .out_num   (sq_p_num)
   );

   ata_sqrt u_sqrt_roll (
      .clock, .reset, .en,
      .in_valid  (s2_valid_ff),
      .in_sum    (s2_sum_r_ff),
      .in_num    (s2_num_r_ff),
      .out_valid (sq_r_valid),
      .out_root  (sq_r_root),
      .out_num   (sq_r_num)
   );

   // angle of each numerator over its root
   logic             cd_p_valid, cd_r_valid, cd_p_zero, cd_r_zero;
   ata_pkg::ang_type cd_p_ang, cd_r_ang;

   ata_cordic #(.Steps(CORDIC_STEPS)) u_cordic_pitch (
      .clock, .reset, .en,
      .in_valid  (sq_p_valid),
      .in_den    (sq_p_root),
      .in_num    (sq_p_num),
      .out_valid (cd_p_valid),
      .out_zero  (cd_p_zero),
      .out_ang   (cd_p_ang)
   );

   ata_cordic #(.Steps(CORDIC_STEPS)) u_cordic_roll (
      .clock, .reset, .en,
      .in_valid  (sq_r_valid),
      .in_den    (sq_r_root),
      .in_num    (sq_r_num),
      .out_valid (cd_r_valid),
      .out_zero  (cd_r_zero),
      .out_ang   (cd_r_ang)
   );

   // clamp to +-90 degrees and round to q8.8; the clamp keeps the
   // rounded value within +-23040 already
   ata_pkg::ang_type   p_clamp, r_clamp, p_rnd, r_rnd;
   logic signed [15:0] pitch_in, roll_in, pitch_abs, roll_abs;
   logic               alert_in;

   always_comb begin
      p_clamp = cd_p_ang;
      if (cd_p_ang > ata_pkg::Deg90Q16)  p_clamp = ata_pkg::Deg90Q16;
      if (cd_p_ang < -ata_pkg::Deg90Q16) p_clamp = -ata_pkg::Deg90Q16;
      r_clamp = cd_r_ang;
      if (cd_r_ang > ata_pkg::Deg90Q16)  r_clamp = ata_pkg::Deg90Q16;
      if (cd_r_ang < -ata_pkg::Deg90Q16) r_clamp = -ata_pkg::Deg90Q16;
      p_rnd = (p_clamp + ata_pkg::RoundQ8) >>> 8;
      r_rnd = (r_clamp + ata_pkg::RoundQ8) >>> 8;
      // all-zero sample gives a zero angle rather than the clamped -90 from the cordic
      pitch_in  = cd_p_zero ? 16'sd0 : p_rnd[15:0];
      roll_in   = cd_r_zero ? 16'sd0 : r_rnd[15:0];
      pitch_abs = pitch_in[15] ? -pitch_in : pitch_in;
      roll_abs  = roll_in[15] ? -roll_in : roll_in;
      alert_in  = (pitch_abs > $signed({1'b0, tilt_limit_ff}))
               || (roll_abs > $signed({1'b0, tilt_limit_ff}));
   end

   // output register
   logic               rsp_valid_ff, rsp_alert_ff;
   logic signed [15:0] rsp_pitch_ff, rsp_roll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= cd_p_valid && cd_r_valid;
      end
      if (en) begin
         rsp_pitch_ff <= pitch_in;
         rsp_roll_ff  <= roll_in;
         rsp_alert_ff <= alert_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pitch_angle = rsp_pitch_ff;
   assign rsp_roll_angle  = rsp_roll_ff;
   assign rsp_tilt_alert  = rsp_alert_ff;

`ifndef NO_ASSERTIONS
   // both angle paths carry the same transactions
   a_paths_aligned: assert property (@(posedge clock) disable iff (reset)
      (cd_p_valid == cd_r_valid))
      else $error("pitch and roll pipelines out of step");

   // delivered angles stay within +-90 degrees
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= Deg90Q8) && (rsp_pitch_angle >= -Deg90Q8)
                 && (rsp_roll_angle <= Deg90Q8) && (rsp_roll_angle >= -Deg90Q8))
      else $error("angle outside +-90 degrees");

   // a stalled output holds the whole pipeline
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while output stalled");
`endif

endmodule

`default_nettype wire
